@@ hdl/tlst_pkg.sv @@
// ----------------------------------------------------------------------------
// tlst_pkg
// Shared codes, field widths and the stored timer entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tlst_pkg;

  localparam int ACTION_W = 2;
  localparam int ID_W     = 16;
  localparam int DUR_W    = 31;
  localparam int PLACE_W  = 2;
  localparam int ELAP_W   = 16;
  localparam int KIND_W   = 2;
  localparam int THR_W    = 7;

  localparam logic [THR_W-1:0] THR_RESET = 7'd48;

  localparam logic [ACTION_W-1:0] ACT_ADD_PERIODIC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD_ONESHOT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK         = 2'd2;

  localparam logic [PLACE_W-1:0] PLACE_MAIN   = 2'd0;
  localparam logic [PLACE_W-1:0] PLACE_WORKER = 2'd1;

  localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

  localparam logic LIST_MAIN   = 1'b0;
  localparam logic LIST_WORKER = 1'b1;

  // remaining is never negative once stored, so it fits the duration width
  typedef struct packed {
    logic [DUR_W-1:0] remaining;
    logic [DUR_W-1:0] interval;
    logic [ID_W-1:0]  ident;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

@@ hdl/two_list_software_timer_table.sv @@
// ----------------------------------------------------------------------------
// two_list_software_timer_table
// Two ordered timer lists (main, worker) with add and tick commands.
//
// Input channel (in_valid/in_stall) carries one command word: an add of a
// periodic or one-shot task, or a tick of one list. Output channel
// (out_valid/out_stall) carries result words; the final word of a command
// has last set. Both lists share one RAM of entries, addressed {list, slot}.
// Add: the accepted/rejected word is in the output register on the next
// cycle. A tick walks the list (up to SLOTS entries) one entry per cycle
// through a single compare/subtract unit, compacting survivors in place. A
// tick that fires nothing gives no word. The block takes no new command
// during a tick. Fired words are held one behind so last can be marked; the
// walk pauses on a firing entry while a word is pending and the receiver
// stalls. Reset (rst, synchronous) empties both lists and sets auto_threshold
// to 48; no clearing pass is needed. cfg_we writes auto_threshold; the user
// must do so only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module two_list_software_timer_table #(
  parameter int SLOTS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tlst_pkg::THR_W-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [tlst_pkg::ACTION_W-1:0]  action,
  input  wire logic [tlst_pkg::ID_W-1:0]      task_id,
  input  wire logic [tlst_pkg::DUR_W-1:0]     duration_ms,
  input  wire logic [tlst_pkg::PLACE_W-1:0]   placement,
  input  wire logic [tlst_pkg::ELAP_W-1:0]    elapsed_ms,
  input  wire logic                           tick_list,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [tlst_pkg::KIND_W-1:0]    kind,
  output logic      [tlst_pkg::ID_W-1:0]      fired_id,
  output logic                                which_list,
  output logic                                last
);

  import tlst_pkg::*;

  localparam int IW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 << IW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]        state;
  logic [THR_W-1:0]  auto_threshold;
  logic [CW-1:0]     main_count;
  logic [CW-1:0]     worker_count;
  logic [CW-1:0]     scan_cnt;
  logic [IW-1:0]     j;
  logic [CW-1:0]     w;
  logic              scan_list;
  logic [ELAP_W-1:0] elapsed;
  logic              pend_valid;
  logic [ID_W-1:0]   pend_id;

  logic              accept;
  logic              out_ok;
  logic              out_load;
  logic              is_add;
  logic              sel;
  logic [CW-1:0]     sel_count;
  logic              full;
  logic              fire;
  logic              keep;
  logic              advance;
  logic              j_last;
  logic [CW-1:0]     w_next;
  logic [DUR_W-1:0]  diff;
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;

  assign out_ok   = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_ok;
  assign accept   = in_valid && !in_stall;
  assign is_add   = (action == ACT_ADD_PERIODIC) || (action == ACT_ADD_ONESHOT);

  always_comb begin
    case (placement)
      PLACE_MAIN:   sel = LIST_MAIN;
      PLACE_WORKER: sel = LIST_WORKER;
      default:      sel = (THR_W'(worker_count) < auto_threshold) &&
                          (THR_W'(main_count) > auto_threshold);
    endcase
  end

  assign sel_count = sel ? worker_count : main_count;
  assign full      = (sel_count == CW'(SLOTS));

  // shared compare/subtract unit for the walk
  assign rd_entry = entry_t'(ram_rdata);
  assign fire     = (rd_entry.remaining <= DUR_W'(elapsed));
  assign diff     = rd_entry.remaining - DUR_W'(elapsed);
  assign keep     = !fire || (rd_entry.interval != '0);
  assign advance  = !(fire && pend_valid && !out_ok);
  assign j_last   = (CW'(j) == scan_cnt - 1'b1);
  assign w_next   = w + CW'(keep);

  assign out_load = ((state == S_IDLE) && accept && is_add) ||
                    ((state == S_SCAN) && advance && fire && pend_valid) ||
                    ((state == S_FLUSH) && pend_valid && out_ok);

  always_comb begin
    wr_entry  = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_raddr = {tick_list, {IW{1'b0}}};
    case (state)
      S_IDLE: begin
        wr_entry.remaining = duration_ms;
        wr_entry.interval  = (action == ACT_ADD_PERIODIC) ? duration_ms : '0;
        wr_entry.ident     = task_id;
        ram_we             = accept && is_add && !full;
        ram_waddr          = {sel, sel_count[IW-1:0]};
      end
      S_SCAN: begin
        wr_entry.remaining = fire ? rd_entry.interval : diff;
        wr_entry.interval  = rd_entry.interval;
        wr_entry.ident     = rd_entry.ident;
        ram_we             = advance && keep;
        ram_waddr          = {scan_list, w[IW-1:0]};
        ram_raddr          = {scan_list, advance ? j + 1'b1 : j};
      end
      default: begin
        ram_raddr = {scan_list, j};
      end
    endcase
  end

  tlst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      auto_threshold <= THR_RESET;
      main_count     <= '0;
      worker_count   <= '0;
      scan_cnt       <= '0;
      j              <= '0;
      w              <= '0;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        auto_threshold <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && is_add) begin
            kind       <= full ? KIND_REJECTED : KIND_ACCEPTED;
            fired_id   <= task_id;
            which_list <= sel;
            last       <= 1'b1;
            if (!full) begin
              if (sel) begin
                worker_count <= worker_count + 1'b1;
              end else begin
                main_count <= main_count + 1'b1;
              end
            end
          end else if (accept && action == ACT_TICK) begin
            scan_list  <= tick_list;
            elapsed    <= elapsed_ms;
            j          <= '0;
            w          <= '0;
            pend_valid <= 1'b0;
            scan_cnt   <= tick_list ? worker_count : main_count;
            if ((tick_list ? worker_count : main_count) != '0) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (advance) begin
            w <= w_next;
            if (fire) begin
              if (pend_valid) begin
                kind       <= KIND_FIRED;
                fired_id   <= pend_id;
                which_list <= scan_list;
                last       <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_id    <= rd_entry.ident;
            end
            if (j_last) begin
              state <= S_FLUSH;
              if (scan_list) begin
                worker_count <= w_next;
              end else begin
                main_count <= w_next;
              end
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_ok) begin
            kind       <= KIND_FIRED;
            fired_id   <= pend_id;
            which_list <= scan_list;
            last       <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (main_count <= CW'(SLOTS)) && (worker_count <= CW'(SLOTS)))
    else $error("list count above SLOTS");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (w <= CW'(j)))
    else $error("compaction write passed the read index");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CW'(j) < scan_cnt))
    else $error("walk index beyond list count");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("fired word left pending at idle");
`endif

endmodule

`default_nettype wire

@@ hdl/tlst_ram.sv @@
// ----------------------------------------------------------------------------
// tlst_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tlst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ tb/sv/timer_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_table_checker
// Watches the command and result channels of the timer table. Keeps its own
// copy of both lists and of the threshold, works out the result words that
// each accepted command owes, and compares every accepted result word, field
// by field, against the oldest word still owed.
// ----------------------------------------------------------------------------
module timer_table_checker
  import tlst_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [THR_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [ACTION_W-1:0] action,
  input  logic [ID_W-1:0]     task_id,
  input  logic [DUR_W-1:0]    duration_ms,
  input  logic [PLACE_W-1:0]  placement,
  input  logic [ELAP_W-1:0]   elapsed_ms,
  input  logic                tick_list,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [ID_W-1:0]     fired_id,
  input  logic                which_list,
  input  logic                last,
  output int                  fail_count,
  output int                  pending
);

  localparam longint REM_FLOOR = -64'sd2147483648;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic              lst;
    logic              last;
  } result_word_t;

  result_word_t     owed [$];
  result_word_t     head;
  int               remaining [2][SLOTS];
  logic [DUR_W-1:0] interval  [2][SLOTS];
  logic [ID_W-1:0]  ident     [2][SLOTS];
  int               list_len  [2];
  logic [THR_W-1:0] threshold;

  task automatic owe(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic lst, logic lw);
    result_word_t w;
    w.kind = k;
    w.id   = id;
    w.lst  = lst;
    w.last = lw;
    owed = {owed, w};
  endtask

  task automatic add_timer(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                           logic [DUR_W-1:0] dur, logic [PLACE_W-1:0] pl);
    logic sel;
    if (pl == PLACE_MAIN) begin
      sel = LIST_MAIN;
    end else if (pl == PLACE_WORKER) begin
      sel = LIST_WORKER;
    end else begin
      sel = (list_len[LIST_WORKER] < int'(threshold)) &&
            (list_len[LIST_MAIN] > int'(threshold));
    end
    if (list_len[sel] >= SLOTS) begin
      owe(KIND_REJECTED, id, sel, 1'b1);
    end else begin
      remaining[sel][list_len[sel]] = int'(dur);
      interval[sel][list_len[sel]]  = (act == ACT_ADD_PERIODIC) ? dur : '0;
      ident[sel][list_len[sel]]     = id;
      list_len[sel]++;
      owe(KIND_ACCEPTED, id, sel, 1'b1);
    end
  endtask

  // decrement in list order, reload what fired, then squeeze out the dead
  task automatic walk_tick(logic lst, logic [ELAP_W-1:0] elap);
    longint          r;
    int              w;
    logic [ID_W-1:0] fired [$];
    w = 0;
    for (int i = 0; i < list_len[lst]; i++) begin
      r = longint'(remaining[lst][i]) - longint'(elap);
      if (r < REM_FLOOR) r = REM_FLOOR;
      if (r <= 0) begin
        fired = {fired, ident[lst][i]};
        r = longint'(interval[lst][i]);
      end
      remaining[lst][i] = int'(r);
    end
    for (int i = 0; i < list_len[lst]; i++) begin
      if (remaining[lst][i] > 0) begin
        remaining[lst][w] = remaining[lst][i];
        interval[lst][w]  = interval[lst][i];
        ident[lst][w]     = ident[lst][i];
        w++;
      end
    end
    list_len[lst] = w;
    foreach (fired[k]) owe(KIND_FIRED, fired[k], lst, k == fired.size() - 1);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_len[LIST_MAIN]   = 0;
      list_len[LIST_WORKER] = 0;
      threshold             = THR_RESET;
      fail_count            = 0;
      owed.delete();
    end else begin
      if (cfg_we) threshold = cfg_wdata;
      if (in_valid && !in_stall) begin
        case (action)
          ACT_ADD_PERIODIC, ACT_ADD_ONESHOT: begin
            add_timer(action, task_id, duration_ms, placement);
          end
          ACT_TICK: begin
            walk_tick(tick_list, elapsed_ms);
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed.size() == 0) begin
          $error("result word with nothing owed: kind %0d id %0d list %0d last %0d",
                 kind, fired_id, which_list, last);
          fail_count++;
        end else begin
          head = owed.pop_front();
          check_field("kind", 32'(head.kind), 32'(kind));
          check_field("fired_id", 32'(head.id), 32'(fired_id));
          check_field("which_list", 32'(head.lst), 32'(which_list));
          check_field("last", 32'(head.last), 32'(last));
        end
      end
    end
    pending = owed.size();
  end

endmodule

@@ tb/sv/tb_two_list_software_timer_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_list_software_timer_table
// Drives add and tick command words into the timer table with random gaps,
// random output stalls and one long output hold-off that backs up the input.
// A short directed run comes first, then random phases under different
// auto thresholds (all but the first written while quiet). The checker beside
// the block does all prediction and comparison; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_two_list_software_timer_table;
  import tlst_pkg::*;

  localparam int SLOTS         = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = SLOTS + 8;
  localparam int NUM_PHASES    = 6;

  localparam logic [ACTION_W-1:0] ACT_IGNORED    = 2'd3;
  localparam logic [PLACE_W-1:0]  PLACE_AUTO     = 2'd2;
  localparam logic [PLACE_W-1:0]  PLACE_AUTO_ALT = 2'd3;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [THR_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     task_id;
  logic [DUR_W-1:0]    duration_ms;
  logic [PLACE_W-1:0]  placement;
  logic [ELAP_W-1:0]   elapsed_ms;
  logic                tick_list;
  logic                out_valid;
  logic                out_stall;
  logic [KIND_W-1:0]   kind;
  logic [ID_W-1:0]     fired_id;
  logic                which_list;
  logic                last;

  int   fail_count;
  int   pending;
  bit   gappy     = 1'b1;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  two_list_software_timer_table #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .task_id    (task_id),
    .duration_ms(duration_ms),
    .placement  (placement),
    .elapsed_ms (elapsed_ms),
    .tick_list  (tick_list),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .fired_id   (fired_id),
    .which_list (which_list),
    .last       (last)
  );

  timer_table_checker #(
    .SLOTS(SLOTS)
  ) u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(64'd400_000_000);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 3);
    if (p < 93) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DUR_W-1:0] rand_dur(bit long_dur);
    int p;
    p = $urandom_range(0, 99);
    if (long_dur) return DUR_W'($urandom_range(1000, 200000));
    if (p < 5) return '0;
    if (p < 70) return DUR_W'($urandom_range(1, 300));
    if (p < 90) return DUR_W'($urandom_range(300, 5000));
    return DUR_W'($urandom);
  endfunction

  function automatic logic [ELAP_W-1:0] rand_elapsed();
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) return '0;
    if (p < 80) return ELAP_W'($urandom_range(1, 150));
    if (p < 93) return ELAP_W'($urandom_range(150, 3000));
    if (p < 97) return '1;
    return ELAP_W'($urandom);
  endfunction

  // hold the word until accepted, then maybe leave a gap
  task automatic offer_word(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                            logic [DUR_W-1:0] dur, logic [PLACE_W-1:0] pl,
                            logic [ELAP_W-1:0] el, logic tl);
    int n;
    in_valid    <= 1'b1;
    action      <= act;
    task_id     <= id;
    duration_ms <= dur;
    placement   <= pl;
    elapsed_ms  <= el;
    tick_list   <= tl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gappy && $urandom_range(0, 2) == 0) begin
      n = gap_len();
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: random stall bursts in segments, one long hold-off on request
  initial begin
    int burst;
    int seg;
    int mode;
    out_stall <= 1'b0;
    burst = 0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 150);
      repeat (seg) begin
        if (burst > 0) burst--;
        else if (mode != 0 && $urandom_range(0, 99) < mode * 12) burst = gap_len();
        out_stall <= (burst > 0);
        @(posedge clk);
        if (hold_req && !hold_done) break;
      end
    end
  end

  initial begin
    int                  done;
    int                  r;
    int                  n_items;
    int                  p_tick;
    int                  p_per;
    int                  p_main;
    bit                  long_dur;
    logic [THR_W-1:0]    thr;
    logic [ACTION_W-1:0] act;
    logic [PLACE_W-1:0]  pl;

    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_wdata   <= THR_RESET;
    in_valid    <= 1'b0;
    action      <= ACT_TICK;
    task_id     <= '0;
    duration_ms <= '0;
    placement   <= PLACE_MAIN;
    elapsed_ms  <= '0;
    tick_list   <= LIST_MAIN;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, extremes, zero duration, one-shot, ignored code
    offer_word(ACT_TICK, 16'h8001, '0, PLACE_MAIN, 16'h8000, LIST_WORKER);
    offer_word(ACT_ADD_PERIODIC, 16'h0000, '0, PLACE_MAIN, '0, LIST_MAIN);
    offer_word(ACT_ADD_ONESHOT, 16'hFFFF, '1, PLACE_WORKER, '1, LIST_WORKER);
    offer_word(ACT_ADD_PERIODIC, 16'hA5A5, 31'd5, PLACE_AUTO_ALT, 16'h5A5A, LIST_MAIN);
    offer_word(ACT_ADD_ONESHOT, 16'h5A5A, 31'd1, PLACE_AUTO, 16'hA5A5, LIST_WORKER);
    offer_word(ACT_TICK, 16'h1111, 31'h2AAA_AAAA, PLACE_MAIN, 16'd0, LIST_MAIN);
    offer_word(ACT_TICK, 16'h2222, 31'h5555_5555, PLACE_WORKER, 16'd1, LIST_MAIN);
    offer_word(ACT_TICK, 16'h3333, '0, PLACE_AUTO, 16'hFFFF, LIST_MAIN);
    offer_word(ACT_TICK, 16'h4444, '1, PLACE_AUTO_ALT, 16'hFFFF, LIST_WORKER);
    offer_word(ACT_IGNORED, 16'hFFFF, '1, PLACE_AUTO_ALT, '1, LIST_WORKER);
    offer_word(ACT_ADD_ONESHOT, 16'h1234, '0, PLACE_WORKER, '0, LIST_MAIN);
    offer_word(ACT_TICK, 16'h5555, '0, PLACE_MAIN, 16'd0, LIST_WORKER);
    for (int k = 0; k < 3; k++) begin
      offer_word(ACT_ADD_PERIODIC, ID_W'(16'h0100 + k), 31'd2, PLACE_MAIN, '0, LIST_MAIN);
    end
    offer_word(ACT_TICK, 16'h6666, '0, PLACE_MAIN, 16'd2, LIST_MAIN);
    offer_word(ACT_TICK, 16'h7777, '0, PLACE_MAIN, 16'd5, LIST_MAIN);
    offer_word(ACT_ADD_PERIODIC, 16'h7FFF, 31'h4000_0000, PLACE_AUTO, '0, LIST_MAIN);
    offer_word(ACT_TICK, 16'h8888, '0, PLACE_MAIN, 16'd0, LIST_WORKER);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      long_dur = 1'b0;
      case (ph)
        0: begin thr = THR_RESET; n_items = 50; p_tick = 35; p_per = 30; p_main = 30; end
        1: begin
          thr = 7'd0; n_items = 80; p_tick = 5; p_per = 40; p_main = 80; long_dur = 1'b1;
        end
        2: begin thr = 7'd64; n_items = 50; p_tick = 30; p_per = 30; p_main = 30; end
        3: begin thr = 7'd3;  n_items = 60; p_tick = 40; p_per = 25; p_main = 20; end
        4: begin thr = 7'd63; n_items = 60; p_tick = 30; p_per = 25; p_main = 20; end
        default: begin
          thr = THR_W'($urandom_range(0, 64)); n_items = 60; p_tick = 45; p_per = 25;
          p_main = 30;
        end
      endcase
      if (ph > 0) write_threshold(thr);
      if (ph == 1) hold_req = 1'b1;
      gappy = ($urandom_range(0, 2) != 0);
      done = 0;
      while (done < n_items) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          offer_word(ACT_IGNORED, ID_W'($urandom), rand_dur(1'b0),
                     PLACE_W'($urandom_range(0, 3)), rand_elapsed(), 1'($urandom_range(0, 1)));
        end else begin
          if (r < 4 + p_tick) begin
            offer_word(ACT_TICK, ID_W'($urandom), DUR_W'($urandom),
                       PLACE_W'($urandom_range(0, 3)), rand_elapsed(),
                       1'($urandom_range(0, 1)));
          end else begin
            act = ($urandom_range(0, 99) < p_per) ? ACT_ADD_PERIODIC : ACT_ADD_ONESHOT;
            pl  = ($urandom_range(0, 99) < p_main) ? PLACE_MAIN
                                                    : PLACE_W'($urandom_range(1, 3));
            offer_word(act, ID_W'($urandom), rand_dur(long_dur), pl,
                       ELAP_W'($urandom), 1'($urandom_range(0, 1)));
          end
          done++;
        end
      end
    end

    wait_quiet();
    if (pending != 0) $error("%0d result words never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
